/* src/ssbt_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted slot booking table package
// Shared types, operation codes and status codes of the slot booking table.
// ----------------------------------------------------------------------------
package ssbt_pkg;

    localparam int unsigned TIME_W = 16;
    localparam int unsigned COUNT_W = 5;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_BOOK   = 3'd1;
    localparam logic [2:0] OP_CANCEL = 3'd2;
    localparam logic [2:0] OP_SORT   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NO_ENTRY = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    typedef struct packed {
        logic [TIME_W-1:0] open_time;
        logic [TIME_W-1:0] close_time;
        logic [TIME_W-1:0] minimum;
        logic              booked;
    } slot_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_MARK,
        ST_SORT_FIRST,
        ST_SORT_SCAN,
        ST_SORT_END
    } state_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 5'd1;
    endfunction

endpackage

/* src/ssbt_mem.sv */
// ----------------------------------------------------------------------------
// Slot store memory
// Synchronous memory of slot entries with one write port and one read port.
// ----------------------------------------------------------------------------
module ssbt_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  ssbt_pkg::slot_entry_t wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output ssbt_pkg::slot_entry_t rd_data
);

    ssbt_pkg::slot_entry_t store_reg [DEPTH];
    ssbt_pkg::slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/sorted_slot_booking_table_core.sv */
// ----------------------------------------------------------------------------
// Sorted slot booking table core
// A table of time slots kept in a synchronous memory, with load, book,
// cancel, stable bubble sort on start time, and read by index.
// ----------------------------------------------------------------------------
// Load and unknown operations finish without leaving idle; read goes through a wait state.
// Book and cancel make one memory read port access per entry.
// Each sort pass scans the entries below a bound that shrinks by one per pass; sort exits
// after a pass without swaps, or once the bound falls below two.
// A new transfer is accepted in the cycle that done is high.
// Reset clears the entry count and the controller; memory contents are not cleared.
module sorted_slot_booking_table_core #(
    parameter int unsigned SLOT_CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         opcode,
    input  logic [15:0]        slot_start,
    input  logic [15:0]        slot_end,
    input  logic [15:0]        slot_minimum,
    input  logic [3:0]         entry_index,
    output logic               done,
    output logic [1:0]         status,
    output logic [4:0]         changed_count,
    output logic [4:0]         refused_count,
    output logic [15:0]        out_start,
    output logic [15:0]        out_end,
    output logic [15:0]        out_minimum,
    output logic signed [16:0] out_span,
    output logic               out_booked
);

    localparam int unsigned AW = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
    localparam int unsigned CW = $clog2(SLOT_CAPACITY + 1);
    localparam int unsigned IW = (CW > 4) ? CW : 4;

    ssbt_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]    dat_ptr_reg, dat_ptr_next;
    logic [CW-1:0]    bound_reg, bound_next;
    logic [15:0]      key_reg, key_next;
    logic             want_reg, want_next;
    logic             swapped_reg, swapped_next;
    ssbt_pkg::slot_entry_t carry_reg, carry_next;
    logic [1:0]       status_reg, status_next;
    logic [4:0]       changed_reg, changed_next;
    logic [4:0]       refused_reg, refused_next;
    logic [15:0]      out_start_reg, out_start_next;
    logic [15:0]      out_end_reg, out_end_next;
    logic [15:0]      out_minimum_reg, out_minimum_next;
    logic [16:0]      out_span_reg, out_span_next;
    logic             out_booked_reg, out_booked_next;

    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    ssbt_pkg::slot_entry_t mem_wr_data;
    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    ssbt_pkg::slot_entry_t mem_rd_data;

    logic [IW-1:0] idx_ext;
    logic [IW-1:0] cnt_ext;
    logic [CW-1:0] bound_m1;

    assign idx_ext  = IW'(entry_index);
    assign cnt_ext  = IW'(count_reg);
    assign bound_m1 = bound_reg - CW'(1);

    ssbt_mem #(
        .DEPTH (SLOT_CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssbt_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg      <= rd_ptr_next;
        dat_ptr_reg     <= dat_ptr_next;
        bound_reg       <= bound_next;
        key_reg         <= key_next;
        want_reg        <= want_next;
        swapped_reg     <= swapped_next;
        carry_reg       <= carry_next;
        status_reg      <= status_next;
        changed_reg     <= changed_next;
        refused_reg     <= refused_next;
        out_start_reg   <= out_start_next;
        out_end_reg     <= out_end_next;
        out_minimum_reg <= out_minimum_next;
        out_span_reg    <= out_span_next;
        out_booked_reg  <= out_booked_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        done_next        = 1'b0;
        rd_ptr_next      = rd_ptr_reg;
        dat_ptr_next     = dat_ptr_reg;
        bound_next       = bound_reg;
        key_next         = key_reg;
        want_next        = want_reg;
        swapped_next     = swapped_reg;
        carry_next       = carry_reg;
        status_next      = status_reg;
        changed_next     = changed_reg;
        refused_next     = refused_reg;
        out_start_next   = out_start_reg;
        out_end_next     = out_end_reg;
        out_minimum_next = out_minimum_reg;
        out_span_next    = out_span_reg;
        out_booked_next  = out_booked_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = '0;
        mem_wr_data      = carry_reg;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = '0;

        case (state_reg)
            ssbt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    status_next      = ssbt_pkg::STATUS_OK;
                    changed_next     = '0;
                    refused_next     = '0;
                    out_start_next   = '0;
                    out_end_next     = '0;
                    out_minimum_next = '0;
                    out_span_next    = '0;
                    out_booked_next  = 1'b0;
                    key_next         = slot_start;
                    want_next        = (opcode == ssbt_pkg::OP_BOOK);
                    case (opcode)
                        ssbt_pkg::OP_LOAD:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CW'(SLOT_CAPACITY))
                            begin
                                status_next = ssbt_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = count_reg[AW-1:0];
                                mem_wr_data = '{open_time:  slot_start,
                                                close_time: slot_end,
                                                minimum:    slot_minimum,
                                                booked:     1'b0};
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        ssbt_pkg::OP_BOOK, ssbt_pkg::OP_CANCEL:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                mem_rd_en    = 1'b1;
                                mem_rd_addr  = '0;
                                rd_ptr_next  = CW'(1);
                                dat_ptr_next = '0;
                                state_next   = ssbt_pkg::ST_MARK;
                            end
                        end
                        ssbt_pkg::OP_SORT:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                bound_next  = count_reg;
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = '0;
                                rd_ptr_next = CW'(1);
                                state_next  = ssbt_pkg::ST_SORT_FIRST;
                            end
                        end
                        ssbt_pkg::OP_READ:
                        begin
                            if (idx_ext >= cnt_ext)
                            begin
                                status_next = ssbt_pkg::STATUS_NO_ENTRY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = idx_ext[AW-1:0];
                                state_next  = ssbt_pkg::ST_READ_WAIT;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ssbt_pkg::ST_READ_WAIT:
            begin
                out_start_next   = mem_rd_data.open_time;
                out_end_next     = mem_rd_data.close_time;
                out_minimum_next = mem_rd_data.minimum;
                out_span_next    = {1'b0, mem_rd_data.close_time}
                                 - {1'b0, mem_rd_data.open_time};
                out_booked_next  = mem_rd_data.booked;
                done_next        = 1'b1;
                state_next       = ssbt_pkg::ST_IDLE;
            end
            ssbt_pkg::ST_MARK:
            begin
                if (mem_rd_data.open_time == key_reg)
                begin
                    if (mem_rd_data.booked != want_reg)
                    begin
                        mem_wr_en          = 1'b1;
                        mem_wr_addr        = dat_ptr_reg;
                        mem_wr_data        = mem_rd_data;
                        mem_wr_data.booked = want_reg;
                        changed_next       = ssbt_pkg::sat_inc(changed_reg);
                    end
                    else
                    begin
                        refused_next = ssbt_pkg::sat_inc(refused_reg);
                    end
                end
                if (rd_ptr_reg < count_reg)
                begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = rd_ptr_reg[AW-1:0];
                    rd_ptr_next  = rd_ptr_reg + CW'(1);
                    dat_ptr_next = rd_ptr_reg[AW-1:0];
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ssbt_pkg::ST_IDLE;
                end
            end
            ssbt_pkg::ST_SORT_FIRST:
            begin
                carry_next   = mem_rd_data;
                swapped_next = 1'b0;
                mem_rd_en    = 1'b1;
                mem_rd_addr  = rd_ptr_reg[AW-1:0];
                rd_ptr_next  = rd_ptr_reg + CW'(1);
                dat_ptr_next = rd_ptr_reg[AW-1:0];
                state_next   = ssbt_pkg::ST_SORT_SCAN;
            end
            ssbt_pkg::ST_SORT_SCAN:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = dat_ptr_reg - AW'(1);
                if (carry_reg.open_time > mem_rd_data.open_time)
                begin
                    mem_wr_data  = mem_rd_data;
                    swapped_next = 1'b1;
                end
                else
                begin
                    mem_wr_data = carry_reg;
                    carry_next  = mem_rd_data;
                end
                if (rd_ptr_reg < bound_reg)
                begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = rd_ptr_reg[AW-1:0];
                    rd_ptr_next  = rd_ptr_reg + CW'(1);
                    dat_ptr_next = rd_ptr_reg[AW-1:0];
                end
                else
                begin
                    state_next = ssbt_pkg::ST_SORT_END;
                end
            end
            ssbt_pkg::ST_SORT_END:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = bound_m1[AW-1:0];
                mem_wr_data = carry_reg;
                bound_next  = bound_m1;
                if (!swapped_reg || (bound_m1 < CW'(2)))
                begin
                    done_next  = 1'b1;
                    state_next = ssbt_pkg::ST_IDLE;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = '0;
                    rd_ptr_next = CW'(1);
                    state_next  = ssbt_pkg::ST_SORT_FIRST;
                end
            end
            default:
            begin
                state_next = ssbt_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != ssbt_pkg::ST_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign changed_count = changed_reg;
    assign refused_count = refused_reg;
    assign out_start     = out_start_reg;
    assign out_end       = out_end_reg;
    assign out_minimum   = out_minimum_reg;
    assign out_span      = $signed(out_span_reg);
    assign out_booked    = out_booked_reg;

endmodule

/* src/ssbt_checker.sv */
// ----------------------------------------------------------------------------
// Slot booking table port checker
// Checks the command and result timing seen on the ports of the core, and that error results carry zero data.
// ----------------------------------------------------------------------------
module ssbt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [1:0]         status,
    input logic [4:0]         changed_count,
    input logic [4:0]         refused_count,
    input logic [15:0]        out_start,
    input logic [15:0]        out_end,
    input logic [15:0]        out_minimum,
    input logic signed [16:0] out_span,
    input logic               out_booked
);

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
    else $error("Accepted transfer produced neither work nor a result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
    else $error("Result strobe seen while the core is busy.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
    else $error("Core went idle without delivering a result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ssbt_pkg::STATUS_OK)) |->
        (changed_count == 5'd0 && refused_count == 5'd0 && out_booked == 1'b0
         && out_span == 17'sd0 && out_start == 16'd0 && out_end == 16'd0
         && out_minimum == 16'd0))
    else $error("Error result carries nonzero data.");

endmodule

bind sorted_slot_booking_table_core ssbt_checker u_ssbt_checker (.*);
